/* rtl/bsb_pkg.sv */
// ----------------------------------------------------------------------------
// bsb_pkg: shared types and constants
// Fixed field widths and request codes for the broadcast slot buffer.
// ----------------------------------------------------------------------------
package bsb_pkg;

    localparam int MAX_CONSUMERS = 4;
    localparam int CID_W         = 2;
    localparam int CFG_W         = 3;
    localparam int VAL_W         = 32;
    localparam int PEND_W        = 3;

    typedef logic signed [VAL_W-1:0] word_t;
    typedef logic [CFG_W-1:0]        cfg_t;
    typedef logic [CID_W-1:0]        cid_t;
    typedef logic [PEND_W-1:0]       pend_t;

    localparam logic MODE_DEPOSIT = 1'b0;
    localparam logic MODE_CONSUME = 1'b1;

    localparam word_t RD_EMPTY          = -32'sd1;
    localparam cfg_t  CONSUMERS_DEFAULT = 3'd4;

endpackage

/* rtl/broadcast_slot_buffer_core.sv */
// An accepted request waits in the request register until the result register is free or out_ready is high.
// Throughput: one request per cycle while out_ready stays high.
// Request register, one pass of bookkeeping logic, result register.
// Reset (rst_n, asynchronous): consumer queues empty, free list preloaded with
// all slot indices in order, consumers_in_use = 4. No clearing pass.
// ----------------------------------------------------------------------------
// broadcast_slot_buffer_core
// Slot pool with a free-index queue and one index queue per consumer; each
// deposited value is read once by every active consumer, then its slot frees.
// ----------------------------------------------------------------------------
module broadcast_slot_buffer_core
    import bsb_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_W-1:0]             cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         mode,
    input  logic signed [VAL_W-1:0]      value,
    input  logic [CID_W-1:0]             consumer_id,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         accepted,
    output logic signed [VAL_W-1:0]      read_value,
    output logic                         bad_consumer,
    output logic [$clog2(SLOTS+1)-1:0]   free_count
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS+1);

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(SLOTS-1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

    function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
        next_pos = (p == LAST_POS) ? '0 : p + 1'b1;
    endfunction

    // configuration
    cfg_t  consumers_in_use_reg;
    cfg_t  n_eff;

    // request register
    logic  req_valid_reg;
    logic  req_mode_reg;
    word_t req_value_reg;
    cid_t  req_cid_reg;

    // result register
    logic             out_valid_reg;
    logic             res_accepted_reg;
    word_t            res_value_reg;
    logic             res_bad_reg;
    logic [CNT_W-1:0] res_free_reg;

    // state
    word_t            slot_values_reg [SLOTS];
    pend_t            pending_reg     [SLOTS];
    logic [IDX_W-1:0] free_fifo_reg   [SLOTS];
    logic [IDX_W-1:0] free_head_reg;
    logic [IDX_W-1:0] free_tail_reg;
    logic [CNT_W-1:0] free_slots_reg;
    logic [CNT_W-1:0] free_slots_next;

    logic [IDX_W-1:0] cons_fifo_reg  [MAX_CONSUMERS][SLOTS];
    logic [IDX_W-1:0] cons_head_reg  [MAX_CONSUMERS];
    logic [IDX_W-1:0] cons_tail_reg  [MAX_CONSUMERS];
    logic [CNT_W-1:0] cons_count_reg [MAX_CONSUMERS];

    // datapath
    logic             fire;
    logic             dep_go;
    logic             con_hit;
    logic             bad;
    logic             release_slot;
    logic [IDX_W-1:0] alloc_idx;
    logic [IDX_W-1:0] pop_idx;
    pend_t            pend_cur;
    logic [MAX_CONSUMERS-1:0] push;
    logic [MAX_CONSUMERS-1:0] pop;

    assign fire     = req_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !req_valid_reg || fire;

    always_comb
    begin
        if (consumers_in_use_reg == '0)
            n_eff = 3'd1;
        else if (consumers_in_use_reg > CFG_W'(MAX_CONSUMERS))
            n_eff = CFG_W'(MAX_CONSUMERS);
        else
            n_eff = consumers_in_use_reg;
    end

    always_comb
    begin
        alloc_idx    = free_fifo_reg[free_head_reg];
        pop_idx      = cons_fifo_reg[req_cid_reg][cons_head_reg[req_cid_reg]];
        pend_cur     = pending_reg[pop_idx];
        bad          = (req_mode_reg == MODE_CONSUME) && ({1'b0, req_cid_reg} >= n_eff);
        dep_go       = fire && (req_mode_reg == MODE_DEPOSIT) && (free_slots_reg != '0);
        con_hit      = fire && (req_mode_reg == MODE_CONSUME) && !bad
                       && (free_slots_reg < FULL_CNT)
                       && (cons_count_reg[req_cid_reg] != '0);
        release_slot = con_hit && (pend_cur == pend_t'(1));
        for (int c = 0; c < MAX_CONSUMERS; c++)
        begin
            push[c] = dep_go && (CFG_W'(c) < n_eff) && (cons_count_reg[c] < FULL_CNT);
            pop[c]  = con_hit && (req_cid_reg == CID_W'(c));
        end
        if (dep_go)
            free_slots_next = free_slots_reg - 1'b1;
        else if (release_slot)
            free_slots_next = free_slots_reg + 1'b1;
        else
            free_slots_next = free_slots_reg;
    end

    // configuration and request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumers_in_use_reg <= CONSUMERS_DEFAULT;
            req_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                consumers_in_use_reg <= cfg_wdata;
            if (in_ready)
                req_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_mode_reg  <= mode;
            req_value_reg <= value;
            req_cid_reg   <= consumer_id;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_accepted_reg <= dep_go || con_hit;
            res_value_reg    <= con_hit ? slot_values_reg[pop_idx] : RD_EMPTY;
            res_bad_reg      <= bad;
            res_free_reg     <= free_slots_next;
        end
    end

    // free list and pending counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_tail_reg  <= '0;
            free_slots_reg <= FULL_CNT;
            for (int i = 0; i < SLOTS; i++)
            begin
                free_fifo_reg[i] <= IDX_W'(i);
                pending_reg[i]   <= '0;
            end
        end
        else
        begin
            free_slots_reg <= free_slots_next;
            if (dep_go)
            begin
                free_head_reg          <= next_pos(free_head_reg);
                pending_reg[alloc_idx] <= n_eff;
            end
            else if (con_hit && (pend_cur != '0))
                pending_reg[pop_idx] <= pend_cur - 1'b1;
            if (release_slot)
            begin
                free_fifo_reg[free_tail_reg] <= pop_idx;
                free_tail_reg                <= next_pos(free_tail_reg);
            end
        end
    end

    // consumer queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_CONSUMERS; c++)
            begin
                cons_head_reg[c]  <= '0;
                cons_tail_reg[c]  <= '0;
                cons_count_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < MAX_CONSUMERS; c++)
            begin
                if (push[c])
                begin
                    cons_tail_reg[c]  <= next_pos(cons_tail_reg[c]);
                    cons_count_reg[c] <= cons_count_reg[c] + 1'b1;
                end
                if (pop[c])
                begin
                    cons_head_reg[c]  <= next_pos(cons_head_reg[c]);
                    cons_count_reg[c] <= cons_count_reg[c] - 1'b1;
                end
            end
        end
    end

    // slot values and queue entries
    always_ff @(posedge clk)
    begin
        if (dep_go)
            slot_values_reg[alloc_idx] <= req_value_reg;
        for (int c = 0; c < MAX_CONSUMERS; c++)
        begin
            if (push[c])
                cons_fifo_reg[c][cons_tail_reg[c]] <= alloc_idx;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = res_accepted_reg;
    assign read_value   = res_value_reg;
    assign bad_consumer = res_bad_reg;
    assign free_count   = res_free_reg;

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_slots_reg <= FULL_CNT)
        else $error("free slot count above pool size");

    a_bad_not_served: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && res_bad_reg |-> !res_accepted_reg && (res_value_reg == RD_EMPTY))
        else $error("bad consumer request served");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed request gave no result");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cons_count_reg[0] <= FULL_CNT)
        else $error("consumer queue overfilled");

    a_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        release_slot |-> !dep_go && (free_slots_reg < FULL_CNT))
        else $error("slot released into full free list");

endmodule
